### hdl/binary_to_decimal_ascii_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for binary_to_decimal_ascii_top
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define B2DA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B2DA_ASSERT(label, prop, msg)
`define B2DA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants, types and helpers for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int ValueWidthDef  = 64;
  localparam int ValueBusWidth  = 64;
  localparam int DigitCharWidth = 6;
  localparam int BcdDigitWidth  = 4;

  // ASCII '0' is 6'b11_0000, so a digit code is this prefix and the BCD nibble
  localparam logic [DigitCharWidth-BcdDigitWidth-1:0] AsciiDigitPrefix = 2'b11;

  typedef struct packed {
    logic load;    // take a new value, clear the BCD word
    logic dabble;  // one shift-and-add-3 step
    logic shift;   // drop the top digit, advance to the next
  } b2da_cmd_t;

  typedef struct packed {
    logic top_zero;  // top BCD digit is zero
  } b2da_stat_t;

  // Decimal digits of 2**width - 1 (1233/4096 approximates log10(2))
  function automatic int num_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

### hdl/b2da_dp.sv
// ----------------------------------------------------------------------------
// b2da_dp
// Datapath: binary shift register and BCD word with shift-and-add-3 logic.
// ----------------------------------------------------------------------------
module b2da_dp
  import b2da_pkg::*;
#(
  parameter int ValueWidth = ValueWidthDef
) (
  input  logic                     clk_i,
  input  logic [ValueWidth-1:0]    value_i,
  input  b2da_cmd_t                cmd_i,
  output b2da_stat_t               stat_o,
  output logic [BcdDigitWidth-1:0] digit_o
);

  localparam int NumDigits = num_digits(ValueWidth);
  localparam int BcdWidth  = NumDigits * BcdDigitWidth;

  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BcdWidth-1:0]   bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[BcdDigitWidth*i +: BcdDigitWidth] =
        (bcd_q[BcdDigitWidth*i +: BcdDigitWidth] >= 4'd5) ?
        bcd_q[BcdDigitWidth*i +: BcdDigitWidth] + 4'd3 :
        bcd_q[BcdDigitWidth*i +: BcdDigitWidth];
    end
  end

  always_comb begin
    priority if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
    end else if (cmd_i.dabble) begin
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
    end else if (cmd_i.shift) begin
      bin_d = bin_q;
      bcd_d = {bcd_q[BcdWidth-BcdDigitWidth-1:0], {BcdDigitWidth{1'b0}}};
    end else begin
      bin_d = bin_q;
      bcd_d = bcd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o         = bcd_q[BcdWidth-1 -: BcdDigitWidth];
  assign stat_o.top_zero = (digit_o == '0);

endmodule

### hdl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller: sequences conversion, leading-zero skip and digit output.
// ----------------------------------------------------------------------------
module b2da_ctrl
  import b2da_pkg::*;
#(
  parameter int ValueWidth = ValueWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       last_o,
  input  b2da_stat_t stat_i,
  output b2da_cmd_t  cmd_o
);

  localparam int NumDigits = num_digits(ValueWidth);
  localparam int BitCntW   = $clog2(ValueWidth);
  localparam int DigCntW   = $clog2(NumDigits);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StOut  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_left_q, dig_left_d;
  logic               started_q, started_d;
  logic               skip;
  logic               more_left;

  assign more_left   = (dig_left_q != '0);
  // drop leading zeros until the first significant digit or the units digit
  assign skip        = (state_q == StOut) && !started_q && stat_i.top_zero && more_left;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut) && !skip;
  assign last_o      = !more_left;

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.dabble = (state_q == StConv);
  assign cmd_o.shift  = skip || (out_valid_o && out_ready_i && more_left);

  always_comb begin
    state_d    = state_q;
    bit_cnt_d  = bit_cnt_q;
    dig_left_d = dig_left_q;
    started_d  = started_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d   = StConv;
          bit_cnt_d = '0;
        end
      end
      StConv: begin
        if (bit_cnt_q == BitCntW'(ValueWidth - 1)) begin
          state_d    = StOut;
          dig_left_d = DigCntW'(NumDigits - 1);
          started_d  = 1'b0;
        end else begin
          bit_cnt_d = bit_cnt_q + 1'b1;
        end
      end
      StOut: begin
        if (skip) begin
          dig_left_d = dig_left_q - 1'b1;
        end else if (out_ready_i) begin
          started_d = 1'b1;
          if (more_left) begin
            dig_left_d = dig_left_q - 1'b1;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      bit_cnt_q  <= '0;
      dig_left_q <= '0;
      started_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      bit_cnt_q  <= bit_cnt_d;
      dig_left_q <= dig_left_d;
      started_q  <= started_d;
    end
  end

endmodule

### hdl/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Converts an unsigned binary value to ASCII decimal digits, MSD first.
// ----------------------------------------------------------------------------
// One item at a time: after a value is accepted, a shift-and-add-3 converter
// builds the BCD word, one input bit per cycle; then every digit position of
// that word is either dropped as a leading zero or presented on the output,
// where it waits while out_ready_i is low. The word holds as many digits
// as the widest value has (20 for 64 bits). Bits of value_i above
// VALUE_WIDTH are ignored. last_digit_o marks the units digit; zero gives
// the single digit '0'.
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      value_valid_i,
  output logic                      value_ready_o,
  input  logic [ValueBusWidth-1:0]  value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [DigitCharWidth-1:0] digit_char_o,
  output logic                      last_digit_o
);

  b2da_cmd_t                cmd;
  b2da_stat_t               stat;
  logic [BcdDigitWidth-1:0] digit;

  b2da_ctrl #(
    .ValueWidth (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (value_valid_i),
    .in_ready_o  (value_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_digit_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  b2da_dp #(
    .ValueWidth (VALUE_WIDTH)
  ) u_dp (
    .clk_i   (clk_i),
    .value_i (value_i[VALUE_WIDTH-1:0]),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .digit_o (digit)
  );

  assign digit_char_o = {AsciiDigitPrefix, digit};

  `B2DA_ASSERT(a_no_overlap, !(value_ready_o && out_valid_o), "ready while a digit is pending")
  `B2DA_ASSERT(a_digit_range, out_valid_o |-> (digit_char_o >= 6'd48 && digit_char_o <= 6'd57), "digit out of range")
  `B2DA_ASSERT_NEXT(a_conv_first, value_valid_i && value_ready_o, !out_valid_o, "digit right after accept")

endmodule

### bench/b2da_digit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_digit_checker
// Watches the value and digit channels of the binary to decimal ASCII block,
// predicts the digit string of every accepted value and compares each
// accepted digit, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module b2da_digit_checker
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      value_valid_i,
  input  logic                      value_ready_i,
  input  logic [ValueBusWidth-1:0]  value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [DigitCharWidth-1:0] digit_char_i,
  input  logic                      last_digit_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        values_seen_o,
  output int                        digits_seen_o
);

  localparam int MaxDigits = 20;
  localparam logic [DigitCharWidth-1:0] AsciiZero = 6'd48;

  typedef struct packed {
    logic [DigitCharWidth-1:0] digit_char;
    logic                      last_digit;
  } digit_t;

  digit_t digit_q[$];
  int     fail_cnt;
  int     value_cnt;
  int     digit_cnt;

  task automatic report_mismatch(input string what);
    $display("[%0t] digit check: %s", $time, what);
    fail_cnt++;
  endtask

  // Queue the decimal digits of one value, most significant first.
  function automatic void queue_digits(input logic [ValueBusWidth-1:0] raw);
    logic [ValueBusWidth-1:0] rest;
    logic [3:0]               rev [MaxDigits];
    int                       n;
    digit_t                   d;
    rest = raw & ({ValueBusWidth{1'b1}} >> (ValueBusWidth - VALUE_WIDTH));
    n = 0;
    do begin
      rev[n] = 4'(rest % 10);
      rest   = rest / 10;
      n++;
    end while (rest != 0 && n < MaxDigits);
    for (int k = 0; k < n; k++) begin
      d.digit_char = AsciiZero + DigitCharWidth'(rev[n-1-k]);
      d.last_digit = (k == n - 1);
      digit_q.push_back(d);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    digit_t want;
    if (rst_ni) begin
      // A digit can never belong to a value taken at the same edge, so check first.
      if (out_valid_i && out_ready_i) begin
        digit_cnt++;
        if (digit_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digit 0x%02h last %0b",
                                    digit_char_i, last_digit_i));
        end else begin
          want = digit_q.pop_front();
          if (digit_char_i !== want.digit_char) begin
            report_mismatch($sformatf("digit_char 0x%02h, want 0x%02h",
                                      digit_char_i, want.digit_char));
          end
          if (last_digit_i !== want.last_digit) begin
            report_mismatch($sformatf("last_digit %0b, want %0b on digit 0x%02h",
                                      last_digit_i, want.last_digit, want.digit_char));
          end
        end
      end
      if (value_valid_i && value_ready_i) begin
        value_cnt++;
        queue_digits(value_i);
      end
    end
    fail_count_o  <= fail_cnt;
    pending_o     <= digit_q.size();
    values_seen_o <= value_cnt;
    digits_seen_o <= digit_cnt;
  end

endmodule

### bench/tb_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_top
// Feeds corner and random values into the converter with random gaps on both
// channels, a long output hold-off and a full drain pause; a separate checker
// predicts every digit string and counts mismatches.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_top;
  import b2da_pkg::*;

  localparam int ValueWidth   = ValueWidthDef;
  localparam int RandomValues = 150;
  localparam int LongHold     = 400;
  localparam int TailCycles   = 150;
  localparam int CycleLimit   = 1000000;
  localparam int NumCorners   = 21;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      value_valid_i;
  logic                      value_ready_o;
  logic [ValueBusWidth-1:0]  value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [DigitCharWidth-1:0] digit_char_o;
  logic                      last_digit_o;

  logic sink_idle_en;
  logic hold_start;
  logic hold_off;
  int   stall_left;
  int   fail_count;
  int   pending;
  int   values_seen;
  int   digits_seen;

  logic [ValueBusWidth-1:0] corner_values [NumCorners] = '{
    64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd101,
    64'd1234567890, 64'd4294967295, 64'd4294967296,
    64'd9999999999999999999, 64'd10000000000000000000,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'hFFFF_FFFF_0000_0000, 64'd12345678901234567890
  };

  binary_to_decimal_ascii_top #(
    .VALUE_WIDTH(ValueWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_valid_i(value_valid_i),
    .value_ready_o(value_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  b2da_digit_checker #(
    .VALUE_WIDTH(ValueWidth)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_valid_i(value_valid_i),
    .value_ready_i(value_ready_o),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_i (digit_char_o),
    .last_digit_i (last_digit_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .values_seen_o(values_seen),
    .digits_seen_o(digits_seen)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [ValueBusWidth-1:0] random_value();
    int                       sel;
    logic [ValueBusWidth-1:0] v;
    logic [ValueBusWidth-1:0] pow;
    sel = $urandom_range(0, 9);
    v   = {$urandom, $urandom};
    case (sel)
      0, 1, 2, 3, 4: v = v >> $urandom_range(0, 63);
      5, 6: ;
      7: begin
        pow = 1;
        repeat ($urandom_range(0, 19)) pow = pow * 10;
        v = pow + 64'($urandom_range(0, 4)) - 64'd2;
      end
      8: v = 64'($urandom_range(0, 20));
      default: v = ~(v >> $urandom_range(0, 63));
    endcase
    return v;
  endfunction

  task automatic offer_value(input logic [ValueBusWidth-1:0] v, input bit with_gaps);
    int gap;
    value_i       <= v;
    value_valid_i <= 1'b1;
    do @(posedge clk_i); while (!value_ready_o);
    gap = (with_gaps && !hold_off) ? pick_gap() : 0;
    if (gap != 0) begin
      value_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Output side: random stalls, overridden by the long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (sink_idle_en) begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_ready_i <= (stall_left == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Hold the output off long enough for the block to back up its input.
  initial begin
    hold_off = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d digits still pending", CycleLimit, pending);
    $display("tb_binary_to_decimal_ascii_top failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    value_valid_i = 1'b0;
    value_i       = '0;
    sink_idle_en  = 1'b0;
    hold_start    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner values back to back, output always ready.
    for (int i = 0; i < NumCorners; i++) begin
      offer_value(corner_values[i], 1'b0);
    end
    value_valid_i <= 1'b0;
    wait_drained();

    sink_idle_en <= 1'b1;
    for (int i = 0; i < RandomValues; i++) begin
      if (i == 30) hold_start <= 1'b1;
      if (i == 80) begin
        value_valid_i <= 1'b0;
        wait_drained();
      end
      if (i == 110) sink_idle_en <= 1'b0;
      if (i == 130) sink_idle_en <= 1'b1;
      offer_value(random_value(), !(i >= 110 && i < 130));
    end
    value_valid_i <= 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Converted %0d values into %0d digit characters, from zero to all ones.",
             values_seen, digits_seen);
    $display("Random gaps on both sides, one %0d-cycle output hold-off, one input drain.",
             LongHold);
    if (fail_count == 0) begin
      $display("tb_binary_to_decimal_ascii_top passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_binary_to_decimal_ascii_top failed");
    end
    $finish;
  end

endmodule
